// ===== hw/rtl/ust_pkg.sv =====
// ust_pkg: shared types and codes for the UBJSON stream tokenizer.
// Holds the parser state, token record, marker bytes and kind/error codes.
// No dependencies.
package ust_pkg;

  localparam int MAX_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    MODE_MARKER      = 3'd0,
    MODE_PAYLOAD     = 3'd1,
    MODE_LEN_MARKER  = 3'd2,
    MODE_LEN_PAYLOAD = 3'd3,
    MODE_STRING      = 3'd4
  } mode_t;

  typedef enum logic [4:0] {
    K_NULL     = 5'd0,
    K_NOOP     = 5'd1,
    K_TRUE     = 5'd2,
    K_FALSE    = 5'd3,
    K_INT8     = 5'd4,
    K_UINT8    = 5'd5,
    K_INT16    = 5'd6,
    K_INT32    = 5'd7,
    K_INT64    = 5'd8,
    K_F32      = 5'd9,
    K_F64      = 5'd10,
    K_CHAR     = 5'd11,
    K_STRHDR   = 5'd12,
    K_STRBYTE  = 5'd13,
    K_ARRBEGIN = 5'd14,
    K_ARREND   = 5'd15,
    K_ERROR    = 5'd16
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_NEG_LEN   = 2'd2,
    ERR_TOO_DEEP  = 2'd3
  } err_t;

  // marker bytes (ASCII)
  localparam logic [7:0] CH_NULL  = 8'h5A; // Z
  localparam logic [7:0] CH_NOOP  = 8'h4E; // N
  localparam logic [7:0] CH_TRUE  = 8'h54; // T
  localparam logic [7:0] CH_FALSE = 8'h46; // F
  localparam logic [7:0] CH_INT8  = 8'h69; // i
  localparam logic [7:0] CH_UINT8 = 8'h55; // U
  localparam logic [7:0] CH_INT16 = 8'h49; // I
  localparam logic [7:0] CH_INT32 = 8'h6C; // l
  localparam logic [7:0] CH_INT64 = 8'h4C; // L
  localparam logic [7:0] CH_F32   = 8'h64; // d
  localparam logic [7:0] CH_F64   = 8'h44; // D
  localparam logic [7:0] CH_CHAR  = 8'h43; // C
  localparam logic [7:0] CH_STR   = 8'h53; // S
  localparam logic [7:0] CH_ARRB  = 8'h5B; // [
  localparam logic [7:0] CH_ARRE  = 8'h5D; // ]

  // parser state apart from the array depth
  typedef struct packed {
    mode_t        mode;
    logic [3:0]   vk;     // value kind being collected
    logic [3:0]   bl;     // payload bytes left
    logic [63:0]  shift;  // big-endian accumulator
    logic [30:0]  sr;     // string bytes remaining
  } st_t;

  typedef struct packed {
    kind_t        kind;
    logic [63:0]  value;
    logic [4:0]   depth;
    logic         done;
    err_t         err;
  } tok_t;

endpackage

// ===== hw/rtl/ust_step.sv =====
// ust_step: next-state and token logic for one stream byte.
// Depends on ust_pkg.
module ust_step #(
  parameter int MAX_DEPTH = ust_pkg::MAX_DEPTH_DEF,
  parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic [7:0]    data_byte,
  input  ust_pkg::st_t  st,
  input  logic [DW-1:0] depth,
  output ust_pkg::st_t  st_nxt,
  output logic [DW-1:0] depth_nxt,
  output logic          emit,
  output ust_pkg::tok_t tok
);
  import ust_pkg::*;

  function automatic logic [3:0] kind_bytes(kind_t k);
    case (k)
      K_INT8, K_UINT8, K_CHAR: kind_bytes = 4'd1;
      K_INT16:                 kind_bytes = 4'd2;
      K_INT32, K_F32:          kind_bytes = 4'd4;
      default:                 kind_bytes = 4'd8;
    endcase
  endfunction

  logic [63:0] sh;
  logic [63:0] v;
  logic [3:0]  bl_dec;
  logic [30:0] sr_dec;
  kind_t       vk_kind;
  kind_t       mk;
  logic        mk_val;

  assign sh      = {st.shift[55:0], data_byte};
  assign bl_dec  = st.bl - {3'd0, (st.bl != 4'd0)};
  assign sr_dec  = st.sr - {30'd0, (st.sr != 31'd0)};
  assign vk_kind = kind_t'({1'b0, st.vk});

  // sign extension of the finished payload
  always_comb begin
    case (vk_kind)
      K_INT8:  v = {{56{sh[7]}}, sh[7:0]};
      K_INT16: v = {{48{sh[15]}}, sh[15:0]};
      K_INT32: v = {{32{sh[31]}}, sh[31:0]};
      default: v = sh;
    endcase
  end

  // value markers that are followed by a payload
  always_comb begin
    mk_val = 1'b1;
    case (data_byte)
      CH_INT8:  mk = K_INT8;
      CH_UINT8: mk = K_UINT8;
      CH_INT16: mk = K_INT16;
      CH_INT32: mk = K_INT32;
      CH_INT64: mk = K_INT64;
      CH_F32:   mk = K_F32;
      CH_F64:   mk = K_F64;
      CH_CHAR:  mk = K_CHAR;
      default: begin
        mk     = K_NULL;
        mk_val = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt    = st;
    depth_nxt = depth;
    emit      = 1'b0;
    tok.kind  = K_NULL;
    tok.value = 64'd0;
    tok.done  = 1'b0;
    tok.err   = ERR_NONE;
    case (st.mode)
      MODE_PAYLOAD, MODE_LEN_PAYLOAD: begin
        st_nxt.bl = bl_dec;
        if (bl_dec != 4'd0) begin
          st_nxt.shift = sh;
        end else begin
          st_nxt.shift = 64'd0;
          st_nxt.sr    = v[30:0];
          emit         = 1'b1;
          st_nxt.mode  = MODE_MARKER;
          if (st.mode == MODE_PAYLOAD) begin
            tok.kind  = vk_kind;
            tok.value = v;
          end else if (v[63]) begin
            tok.kind = K_ERROR;
            tok.err  = ERR_NEG_LEN;
          end else begin
            tok.kind = K_STRHDR;
            if (v[30:0] == 31'd0) begin
              tok.done = 1'b1;
            end else begin
              tok.value   = {33'd0, v[30:0]};
              st_nxt.mode = MODE_STRING;
            end
          end
        end
      end
      MODE_LEN_MARKER: begin
        if (mk_val && (mk == K_INT8 || mk == K_UINT8 || mk == K_INT16 || mk == K_INT32)) begin
          st_nxt.vk    = mk[3:0];
          st_nxt.bl    = kind_bytes(mk);
          st_nxt.shift = 64'd0;
          st_nxt.mode  = MODE_LEN_PAYLOAD;
        end else begin
          emit     = 1'b1;
          tok.kind = K_ERROR;
          tok.err  = ERR_UNKNOWN;
        end
      end
      MODE_STRING: begin
        st_nxt.sr = sr_dec;
        emit      = 1'b1;
        tok.kind  = K_STRBYTE;
        tok.value = {56'd0, data_byte};
        if (sr_dec == 31'd0) begin
          tok.done    = 1'b1;
          st_nxt.mode = MODE_MARKER;
        end
      end
      default: begin
        st_nxt.mode = MODE_MARKER;
        if (mk_val) begin
          st_nxt.vk    = mk[3:0];
          st_nxt.bl    = kind_bytes(mk);
          st_nxt.shift = 64'd0;
          st_nxt.mode  = MODE_PAYLOAD;
        end else begin
          emit = 1'b1;
          case (data_byte)
            CH_NULL:  tok.kind = K_NULL;
            CH_NOOP:  tok.kind = K_NOOP;
            CH_TRUE:  tok.kind = K_TRUE;
            CH_FALSE: tok.kind = K_FALSE;
            CH_STR: begin
              emit        = 1'b0;
              st_nxt.mode = MODE_LEN_MARKER;
            end
            CH_ARRB: begin
              if (depth >= DW'(MAX_DEPTH)) begin
                tok.kind = K_ERROR;
                tok.err  = ERR_TOO_DEEP;
              end else begin
                tok.kind  = K_ARRBEGIN;
                depth_nxt = depth + DW'(1);
              end
            end
            CH_ARRE: begin
              if (depth == '0) begin
                tok.kind = K_ERROR;
                tok.err  = ERR_UNKNOWN;
              end else begin
                tok.kind  = K_ARREND;
                depth_nxt = depth - DW'(1);
              end
            end
            default: begin
              tok.kind = K_ERROR;
              tok.err  = ERR_UNKNOWN;
            end
          endcase
        end
      end
    endcase
    // depth after this token, low 5 bits
    tok.depth = 5'(depth_nxt);
  end

endmodule

// ===== hw/rtl/ust_out_reg.sv =====
// ust_out_reg: result register between the tokenizer and the result channel.
// Depends on ust_pkg.
module ust_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          emit,
  input  ust_pkg::tok_t tok,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          can_load,
  output ust_pkg::tok_t tok_q
);
  import ust_pkg::*;

  logic valid_r;
  tok_t tok_r;

  // free when empty or draining this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign tok_q     = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      tok_r <= tok;
    end
  end

endmodule

// ===== hw/rtl/ubjson_stream_tokenizer.sv =====
// ubjson_stream_tokenizer: UBJSON byte stream to token stream, top level.
// Depends on ust_pkg, ust_step, ust_out_reg.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_data_byte[7:0]
//   out     | out | out_valid / out_ready | token_kind, token_value, nesting_depth,
//           |     |                       | string_done, error_code
//
// One byte beat per cycle while in_ready is high: each accepted byte updates the
// parser state and, when it completes a token, loads the result register in the
// same edge. Throughput is set by the single state-update path (byte shift, marker
// decode) and the result register; a token is valid in the cycle after its byte.
// Reset (rst_n low, synchronous) returns to expecting a value marker at depth 0.
// in_ready drops while a token sits in the result register and out_ready is
// low, whether or not the byte on offer would make a token.
module ubjson_stream_tokenizer #(
  parameter int MAX_DEPTH = ust_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [63:0] out_token_value,
  output logic [4:0]  out_nesting_depth,
  output logic        out_string_done,
  output logic [1:0]  out_error_code
);
  import ust_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  st_t           st_r, st_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          emit;
  logic          can_load;
  logic          in_fire;
  tok_t          tok, tok_q;

  ust_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (DW)
  ) u_step (
    .data_byte (in_data_byte),
    .st        (st_r),
    .depth     (depth_r),
    .st_nxt    (st_nxt),
    .depth_nxt (depth_nxt),
    .emit      (emit),
    .tok       (tok)
  );

  ust_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .emit      (emit),
    .tok       (tok),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .tok_q     (tok_q)
  );

  // ready depends only on the result register, not on the byte offered
  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= MODE_MARKER;
      st_r.vk    <= 4'd0;
      st_r.bl    <= 4'd0;
      st_r.shift <= 64'd0;
      st_r.sr    <= 31'd0;
      depth_r    <= '0;
    end else if (in_fire) begin
      st_r    <= st_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign out_token_kind    = tok_q.kind;
  assign out_token_value   = tok_q.value;
  assign out_nesting_depth = tok_q.depth;
  assign out_string_done   = tok_q.done;
  assign out_error_code    = tok_q.err;

`ifndef ASSERT_OFF
  // depth stays within the configured limit
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("array depth above limit");

  // string mode always has bytes left to take
  a_str_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_STRING |-> st_r.sr != 31'd0)
    else $error("string mode with no bytes remaining");

  // every byte of a string body yields a string byte token
  a_str_tok: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.mode == MODE_STRING |=>
      out_valid && out_token_kind == K_STRBYTE)
    else $error("string byte did not produce a token");

  // array end at depth zero is rejected as unknown
  a_arre_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.mode == MODE_MARKER && in_data_byte == CH_ARRE && depth_r == '0 |=>
      out_valid && out_token_kind == K_ERROR && out_error_code == ERR_UNKNOWN)
    else $error("unbalanced array end not flagged");
`endif

endmodule
